@@ design/kth_smallest_selector_assert.svh @@
`ifndef KTH_SMALLEST_SELECTOR_ASSERT_SVH
`define KTH_SMALLEST_SELECTOR_ASSERT_SVH

// same-cycle implication
`define KSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kss assertion failed");

// next-cycle implication
`define KSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kss assertion failed");

`endif

@@ design/kss_pkg.sv @@
package kss_pkg;

   localparam int DEFAULT_STORE_DEPTH = 16;
   localparam int VALUE_W             = 32;
   localparam int RANK_W              = 5;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [RANK_W-1:0]         count_type;

   typedef struct packed {
      logic load;
      logic occupied;
   } cell_ctrl_type;

   function automatic logic value_less(input value_type a, input value_type b);
      return a < b;
   endfunction

endpackage

@@ design/kth_smallest_selector.sv @@
// A word with req_last set first sets the pending flag; the largest kept entry is then
// selected out of the cell row into the output register and shown on rsp_. Words are
// taken at one word per cycle, but req_ready stays low from that pending flag until the
// result is loaded, and longer while an earlier result still waits on rsp_ready.
// Reset (synchronous, active high) empties the store, drops any result, sets rank to 1.
// Cell contents are not reset; only entries below the kept count are ever read.
module kth_smallest_selector
   import kss_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_kth_value,
   output logic [RANK_W-1:0]         rsp_kept_count,
   input  logic                      csr_wr_en,
   input  logic [RANK_W-1:0]         csr_wr_data
);

`include "kth_smallest_selector_assert.svh"

   localparam count_type DEPTH_CAP =
      (STORE_DEPTH > (2**RANK_W - 1)) ? count_type'(2**RANK_W - 1) : count_type'(STORE_DEPTH);

   count_type rank_ff, rank_in;
   count_type kept_total_ff, kept_total_in;
   logic      pend_ff, pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_value_ff, rsp_value_in;
   count_type rsp_count_ff, rsp_count_in;

   count_type rank_eff;
   count_type total_trunc;
   logic      accept;
   logic      rsp_load;
   value_type sel_value;

   cell_ctrl_type ctrl      [STORE_DEPTH];
   value_type     cell_val  [STORE_DEPTH];
   logic          cell_lt   [STORE_DEPTH];
   logic          cell_hit  [STORE_DEPTH];

   assign req_ready      = !pend_ff;
   assign accept         = req_valid && req_ready;
   assign rsp_load       = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kth_value  = rsp_value_ff;
   assign rsp_kept_count = rsp_count_ff;

   always_comb begin
      priority if (rank_ff == '0) begin
         rank_eff = count_type'(1);
      end else if (rank_ff > DEPTH_CAP) begin
         rank_eff = DEPTH_CAP;
      end else begin
         rank_eff = rank_ff;
      end
      total_trunc = (kept_total_ff > rank_eff) ? rank_eff : kept_total_ff;
   end

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      assign ctrl[i].load     = accept;
      assign ctrl[i].occupied = 32'(i) < 32'(total_trunc);
      assign cell_hit[i]      = 32'(i) + 32'd1 == 32'(kept_total_ff);

      if (i == 0) begin : g_head
         kss_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl[i]),
            .ins_value  (req_value),
            .prev_value (req_value),
            .prev_lt    (1'b0),
            .lt         (cell_lt[i]),
            .value      (cell_val[i])
         );
      end else begin : g_body
         kss_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl[i]),
            .ins_value  (req_value),
            .prev_value (cell_val[i-1]),
            .prev_lt    (cell_lt[i-1]),
            .lt         (cell_lt[i]),
            .value      (cell_val[i])
         );
      end
   end

   always_comb begin
      sel_value = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         sel_value = sel_value | (cell_hit[i] ? cell_val[i] : value_type'(0));
      end
   end

   always_comb begin
      rank_in       = csr_wr_en ? csr_wr_data : rank_ff;
      kept_total_in = kept_total_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         kept_total_in = (total_trunc < rank_eff) ? total_trunc + count_type'(1) : total_trunc;
         pend_in       = req_last;
      end
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = sel_value;
         rsp_count_in  = kept_total_ff;
         kept_total_in = '0;
         pend_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff       <= count_type'(1);
         kept_total_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rank_ff       <= rank_in;
         kept_total_ff <= kept_total_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   `KSS_ASSERT_NOW(a_total_capped, clock, reset, 1'b1, kept_total_ff <= DEPTH_CAP)
   `KSS_ASSERT_NOW(a_rsp_count_nonzero, clock, reset, rsp_valid, rsp_kept_count != '0)
   `KSS_ASSERT_NEXT(a_last_pends, clock, reset, accept && req_last, pend_ff && !req_ready)
   `KSS_ASSERT_NEXT(a_load_clears, clock, reset, rsp_load, kept_total_ff == '0 && rsp_valid_ff)

endmodule

@@ design/kss_cell.sv @@
module kss_cell
   import kss_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  value_type     ins_value,
   input  value_type     prev_value,
   input  logic          prev_lt,
   output logic          lt,
   output value_type     value
);

   value_type value_ff;
   value_type value_in;

   assign lt    = !ctrl.occupied || value_less(ins_value, value_ff);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load && lt) begin
         value_in = prev_lt ? prev_value : ins_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ bench/kth_selection_check.sv @@
`timescale 1ns / 1ps
module kth_selection_check
   import kss_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_ready,
   input  value_type req_value,
   input  logic      req_last,
   input  logic      rsp_valid,
   input  logic      rsp_ready,
   input  value_type rsp_kth_value,
   input  count_type rsp_kept_count,
   input  logic      csr_wr_en,
   input  count_type csr_wr_data,
   output int        mismatch_count,
   output int        results_due
);

   typedef struct {
      value_type kth;
      count_type kept;
   } selection_type;

   selection_type selection_q[$];
   value_type     kept_vals[STORE_DEPTH];
   int            kept_n;
   count_type     rank_reg;

   initial begin
      mismatch_count = 0;
      results_due    = 0;
      kept_n         = 0;
      rank_reg       = 1;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic int rank_in_force();
      if (rank_reg == 0) return 1;
      if (rank_reg > STORE_DEPTH) return STORE_DEPTH;
      return rank_reg;
   endfunction

   // keep the k smallest in ascending order; on last, queue the largest kept
   task automatic take_value(input value_type v, input logic last);
      int k;
      int pos;
      selection_type sel;
      k = rank_in_force();
      if (kept_n > k) kept_n = k;
      if (kept_n < k || v < kept_vals[kept_n-1]) begin
         if (kept_n == k) kept_n--;
         pos = kept_n;
         while (pos > 0 && kept_vals[pos-1] > v) begin
            kept_vals[pos] = kept_vals[pos-1];
            pos--;
         end
         kept_vals[pos] = v;
         kept_n++;
      end
      if (last) begin
         sel.kth  = kept_vals[kept_n-1];
         sel.kept = count_type'(kept_n);
         selection_q.push_back(sel);
         kept_n = 0;
      end
   endtask

   always @(posedge clock) begin
      selection_type want;
      if (reset) begin
         selection_q.delete();
         kept_n   = 0;
         rank_reg = 1;
      end else begin
         if (csr_wr_en) rank_reg = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (selection_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result word kth=%0d kept=%0d",
                                         rsp_kth_value, rsp_kept_count));
            end else begin
               want = selection_q.pop_front();
               if (rsp_kth_value !== want.kth)
                  report_mismatch($sformatf("kth_value got %0d want %0d",
                                            rsp_kth_value, want.kth));
               if (rsp_kept_count !== want.kept)
                  report_mismatch($sformatf("kept_count got %0d want %0d",
                                            rsp_kept_count, want.kept));
            end
         end
         if (req_valid && req_ready) take_value(req_value, req_last);
      end
      results_due = selection_q.size();
   end

endmodule

@@ bench/kth_smallest_selector_tb.sv @@
`timescale 1ns / 1ps
module kth_smallest_selector_tb;
   import kss_pkg::*;

   localparam int DEPTH        = DEFAULT_STORE_DEPTH;
   localparam int RANDOM_WORDS = 1550;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANK_MAX     = 31;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   value_type req_value;
   logic      req_last;
   logic      rsp_valid;
   logic      rsp_ready;
   value_type rsp_kth_value;
   count_type rsp_kept_count;
   logic      csr_wr_en;
   count_type csr_wr_data;

   int mismatch_count;
   int results_due;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int words_sent     = 0;
   int sets_sent      = 0;
   int cycle_count    = 0;
   int directed_words;

   kth_smallest_selector #(.STORE_DEPTH(DEPTH)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kth_value  (rsp_kth_value),
      .rsp_kept_count (rsp_kept_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   kth_selection_check #(.STORE_DEPTH(DEPTH)) u_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kth_value  (rsp_kth_value),
      .rsp_kept_count (rsp_kept_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_word(input value_type v, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
      if (last) sets_sent++;
   endtask

   // rank changes only once all results are out and the pipeline has settled
   task automatic write_rank(input count_type k);
      req_valid <= 1'b0;
      wait (results_due == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      wait (results_due == 0);
      @(negedge clock);
   endtask

   function automatic value_type pick_value(input int mode);
      case (mode)
         0: return value_type'($urandom);
         1: return value_type'(int'($urandom_range(0, 8)) - 4);
         2: begin
            case ($urandom_range(0, 3))
               0: return value_type'(32'h8000_0000);
               1: return value_type'(32'h7fff_ffff);
               2: return value_type'(32'h8000_0000 + $urandom_range(0, 3));
               default: return value_type'(32'h7fff_ffff - $urandom_range(0, 3));
            endcase
         end
         default: begin
            if ($urandom_range(0, 1)) return value_type'($urandom);
            return value_type'(int'($urandom_range(0, 16)) - 8);
         end
      endcase
   endfunction

   task automatic send_random_set();
      int len;
      int mode;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 20);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         // occasional rank change in the middle of a set
         if (i == len / 2 && len > 4 && $urandom_range(0, 29) == 0)
            write_rank(count_type'($urandom_range(0, RANK_MAX)));
         send_word(pick_value(mode), i == len - 1);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_value   = '0;
      req_last    = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // rank 1 out of reset
      send_word(5, 1'b0);
      send_word(-3, 1'b0);
      send_word(7, 1'b1);
      send_word(value_type'(32'h8000_0000), 1'b1);

      write_rank(count_type'(DEPTH));
      send_word(value_type'(32'h7fff_ffff), 1'b0);
      send_word(value_type'(32'h8000_0000), 1'b0);
      send_word(-1, 1'b0);
      send_word(0, 1'b0);
      send_word(1, 1'b1);

      // rank zero behaves as one
      write_rank(count_type'(0));
      send_word(10, 1'b0);
      send_word(-10, 1'b1);

      // duplicates of the largest kept entry
      write_rank(count_type'(2));
      send_word(4, 1'b0);
      send_word(4, 1'b0);
      send_word(4, 1'b0);
      send_word(9, 1'b1);

      // rank lowered part way through a set
      write_rank(count_type'(8));
      send_word(3, 1'b0);
      send_word(-8, 1'b0);
      send_word(12, 1'b0);
      send_word(0, 1'b0);
      send_word(-1, 1'b0);
      send_word(6, 1'b0);
      write_rank(count_type'(2));
      send_word(20, 1'b1);

      directed_words = words_sent;

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               write_rank(count_type'(DEPTH));
            end
            1: begin
               send_idle_pct  = 57;
               recv_stall_pct = 0;
               write_rank(count_type'(1));
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 57;
               write_rank(count_type'(RANK_MAX));
            end
            default: begin
               send_idle_pct  = 14;
               recv_stall_pct = 14;
               write_rank(count_type'($urandom_range(0, RANK_MAX)));
            end
         endcase
         while (words_sent - directed_words < RANDOM_WORDS * (p + 1) / 4) begin
            send_random_set();
            if ($urandom_range(0, 14) == 0)
               write_rank(count_type'($urandom_range(0, RANK_MAX)));
            else if (p == 1 && $urandom_range(0, 9) == 0)
               hold_until_drained();
         end
         hold_until_drained();
      end

      req_valid <= 1'b0;
      wait (results_due == 0);
      repeat (DRAIN_CYCLES * 4) @(posedge clock);
      $display("Sent %0d words in %0d sets, ranks 0 to %0d incl. mid-set changes,",
               words_sent, sets_sent, RANK_MAX);
      $display("under free flow, sender gaps, receiver stalls and both together.");
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
